>>> src/moac_pkg.sv
`timescale 1ns / 1ps

package moac_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned SUM16_W  = 16;
  localparam int unsigned SUM32_W  = 32;
  localparam int unsigned LANE_W   = 2;
  localparam int unsigned OUT_W    = 288;

  localparam logic [LANE_W-1:0] LANE_0 = 2'd0;
  localparam logic [LANE_W-1:0] LANE_1 = 2'd1;
  localparam logic [LANE_W-1:0] LANE_2 = 2'd2;
  localparam logic [LANE_W-1:0] LANE_3 = 2'd3;

  // Members listed from the highest bits down, so byte_sum16 lands in bits 15:0.
  typedef struct packed {
    logic [SUM32_W-1:0] dword_sum_swap_word;
    logic [SUM32_W-1:0] dword_sum_le;
    logic [SUM32_W-1:0] dword_sum_swap_hl;
    logic [SUM32_W-1:0] dword_sum_be;
    logic [SUM32_W-1:0] word_sum_be;
    logic [SUM32_W-1:0] word_sum_le;
    logic [SUM32_W-1:0] byte_sum32;
    logic [SUM16_W-1:0] odd_sum16;
    logic [SUM16_W-1:0] even_sum16;
    logic [SUM16_W-1:0] byte_sum_complement16;
    logic [SUM16_W-1:0] byte_sum16;
  } moac_result_t;

endpackage

>>> src/moac_accum.sv
`timescale 1ns / 1ps

module moac_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  input  logic                       start_lsb,
  output moac_pkg::moac_result_t     result
);
  import moac_pkg::*;

  logic [SUM32_W-1:0] acc_bytes, acc_bytes_next;
  logic [SUM16_W-1:0] acc_even, acc_even_next;
  logic [SUM16_W-1:0] acc_odd, acc_odd_next;
  logic [SUM32_W-1:0] acc_word_le, acc_word_le_next;
  logic [SUM32_W-1:0] acc_word_be, acc_word_be_next;
  logic [SUM32_W-1:0] acc_dw_be, acc_dw_be_next;
  logic [SUM32_W-1:0] acc_dw_swap_hl, acc_dw_swap_hl_next;
  logic [SUM32_W-1:0] acc_dw_le, acc_dw_le_next;
  logic [SUM32_W-1:0] acc_dw_swap_word, acc_dw_swap_word_next;
  logic [LANE_W-1:0]  lane_position;
  logic [23:0]        pending_bytes, pending_bytes_next;

  logic [7:0] b0, b1, b2, first;
  logic       odd_addr;
  logic       pair_done;

  always_comb begin
    b0 = pending_bytes[7:0];
    b1 = pending_bytes[15:8];
    b2 = pending_bytes[23:16];
    odd_addr  = start_lsb ^ lane_position[0];
    pair_done = lane_position[0];
    first = (lane_position == LANE_3) ? b2 : b0;

    acc_bytes_next = acc_bytes + {24'd0, data_byte};
    acc_even_next  = odd_addr ? acc_even : acc_even + {8'd0, data_byte};
    acc_odd_next   = odd_addr ? acc_odd + {8'd0, data_byte} : acc_odd;

    acc_word_le_next = acc_word_le;
    acc_word_be_next = acc_word_be;
    if (pair_done) begin
      acc_word_le_next = acc_word_le + {16'd0, data_byte, first};
      acc_word_be_next = acc_word_be + {16'd0, first, data_byte};
    end

    acc_dw_be_next        = acc_dw_be;
    acc_dw_swap_hl_next   = acc_dw_swap_hl;
    acc_dw_le_next        = acc_dw_le;
    acc_dw_swap_word_next = acc_dw_swap_word;
    pending_bytes_next    = pending_bytes;
    unique case (lane_position)
      LANE_0: pending_bytes_next[7:0]   = data_byte;
      LANE_1: pending_bytes_next[15:8]  = data_byte;
      LANE_2: pending_bytes_next[23:16] = data_byte;
      LANE_3: begin
        acc_dw_be_next        = acc_dw_be + {b0, b1, b2, data_byte};
        acc_dw_swap_hl_next   = acc_dw_swap_hl + {b1, b0, data_byte, b2};
        acc_dw_le_next        = acc_dw_le + {data_byte, b2, b1, b0};
        acc_dw_swap_word_next = acc_dw_swap_word + {b2, data_byte, b0, b1};
        pending_bytes_next    = 24'd0;
      end
      default: pending_bytes_next = pending_bytes;
    endcase

    result.byte_sum16            = acc_bytes_next[15:0];
    result.byte_sum_complement16 = ~acc_bytes_next[15:0];
    result.even_sum16            = acc_even_next;
    result.odd_sum16             = acc_odd_next;
    result.byte_sum32            = acc_bytes_next;
    result.word_sum_le           = acc_word_le_next;
    result.word_sum_be           = acc_word_be_next;
    result.dword_sum_be          = acc_dw_be_next;
    result.dword_sum_swap_hl     = acc_dw_swap_hl_next;
    result.dword_sum_le          = acc_dw_le_next;
    result.dword_sum_swap_word   = acc_dw_swap_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      acc_bytes        <= '0;
      acc_even         <= '0;
      acc_odd          <= '0;
      acc_word_le      <= '0;
      acc_word_be      <= '0;
      acc_dw_be        <= '0;
      acc_dw_swap_hl   <= '0;
      acc_dw_le        <= '0;
      acc_dw_swap_word <= '0;
      lane_position    <= '0;
      pending_bytes    <= '0;
    end else if (step) begin
      acc_bytes        <= acc_bytes_next;
      acc_even         <= acc_even_next;
      acc_odd          <= acc_odd_next;
      acc_word_le      <= acc_word_le_next;
      acc_word_be      <= acc_word_be_next;
      acc_dw_be        <= acc_dw_be_next;
      acc_dw_swap_hl   <= acc_dw_swap_hl_next;
      acc_dw_le        <= acc_dw_le_next;
      acc_dw_swap_word <= acc_dw_swap_word_next;
      lane_position    <= lane_position + LANE_1;
      pending_bytes    <= pending_bytes_next;
    end
  end

endmodule

>>> src/moac_out.sv
`timescale 1ns / 1ps

module moac_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  moac_pkg::moac_result_t        result,
  output logic                          free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [moac_pkg::OUT_W-1:0]    m_tdata
);
  import moac_pkg::*;

  moac_result_t held;

  // Room for a new result when empty or when the held one leaves this cycle.
  assign free    = !m_tvalid || m_tready;
  assign m_tdata = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

>>> src/multi_order_additive_checksum.sv
`timescale 1ns / 1ps
// A last byte passes the input register, then the output register raises m_tvalid.
// Throughput: 1 byte per cycle; the input register advances every cycle and
// stalls only when a last byte meets a result still waiting in the output register.
// Reset: synchronous, active high; clears all sums, the lane count, the start
// address and both valid flags.
module multi_order_additive_checksum (
  input  logic         clk,
  input  logic         rst,
  // Configuration: start address, only bit 0 affects the parity sums.
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  // Byte stream in.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte[7:0]
  input  logic         s_tlast,   // last_byte
  // Result out.
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0 up: byte_sum16, byte_sum_complement16, even_sum16,
  // odd_sum16 (16 bits each), byte_sum32, word_sum_le, word_sum_be,
  // dword_sum_be, dword_sum_swap_hl, dword_sum_le, dword_sum_swap_word
  // (32 bits each).
  output logic [moac_pkg::OUT_W-1:0] m_tdata
);
  import moac_pkg::*;

  logic [31:0]  start_address;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         advance;
  logic         out_free;
  moac_result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
    end else if (cfg_wr_en) begin
      start_address <= cfg_wr_data;
    end
  end

  // A plain byte always folds into the sums; a last byte waits for room
  // in the output register.
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Hold the request while the stage is stalled.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  moac_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .start_lsb (start_address[0]),
    .result    (result)
  );

  moac_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && in_last),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
